/* hw/rtl/pbd_pkg.sv */
package pbd_pkg;

  // Block geometry
  localparam int NUM_BLOCKS     = 2;
  localparam int BITS_PER_BLOCK = 8;
  localparam int BLK_W          = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  // Field widths
  localparam int BLOCK_INDEX_W = 1;
  localparam int RAW_W         = BITS_PER_BLOCK;
  localparam int CNT_W         = 16;
  localparam int CFG_INDEX_W   = 4;
  localparam int CFG_DATA_W    = CNT_W;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_TIME_BIT0 = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_TIME_LAST = 4'd7;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef cnt_t [BITS_PER_BLOCK-1:0] filter_times_t;

  // One bit's view of the block state going into an update
  typedef struct packed {
    cnt_t cnt;
    cnt_t filter_time;
    logic raw;
    logic prev_raw;
    logic filt;
  } lane_in_t;

  // Updated state of one bit
  typedef struct packed {
    cnt_t cnt;
    logic filt;
  } lane_out_t;

endpackage

/* hw/rtl/pbd_intf.sv */
// Input sample channel
interface pbd_item_if import pbd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [BLOCK_INDEX_W-1:0] block_index;
  logic [RAW_W-1:0]         raw_inputs;

  modport source (output valid, output block_index, output raw_inputs, input ready);
  modport sink   (input valid, input block_index, input raw_inputs, output ready);
endinterface

// Filtered result channel
interface pbd_result_if import pbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] filtered_inputs;

  modport source (output valid, output filtered_inputs, input ready);
  modport sink   (input valid, input filtered_inputs, output ready);
endinterface

// Register write channel
interface pbd_cfg_if import pbd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/per_bit_input_debounce_filter_top.sv */
// Channel   Dir  Handshake      Payload
// items     in   valid/ready    block_index[0:0], raw_inputs[7:0]
// results   out  valid/ready    filtered_inputs[7:0]
// cfg       in   valid/ready    index[3:0], data[15:0] (ready always high)
//
// One sample per cycle sustained while results.ready stays high. A sample loads the input
// register when it transfers, then moves on into the result register, which presents it.
// The per-block state update is a single pass of eight bit lanes between
// the input register and the result register.
// rst is synchronous: clears filter times, counters, previous and filtered bytes.
// A stalled result also holds a full input register; items.ready drops only when both are full.
module per_bit_input_debounce_filter_top
  import pbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  pbd_item_if.sink   items,
  pbd_result_if.source results,
  pbd_cfg_if.sink    cfg
);

  filter_times_t filter_times;

  // Block state
  cnt_t [BITS_PER_BLOCK-1:0] counters     [NUM_BLOCKS];
  logic [RAW_W-1:0]          prev_raw     [NUM_BLOCKS];
  logic [RAW_W-1:0]          filt_bits    [NUM_BLOCKS];

  // Input register
  logic                     in_valid;
  logic [BLOCK_INDEX_W-1:0] blk_q;
  logic [RAW_W-1:0]         raw_q;

  // Result register
  logic             res_valid;
  logic [RAW_W-1:0] res_data;

  logic             advance;
  logic             in_range;
  logic [BLK_W-1:0] rd_idx;
  logic             update;
  logic [RAW_W-1:0] filt_next;
  cnt_t [BITS_PER_BLOCK-1:0] cnt_next;
  lane_in_t  [BITS_PER_BLOCK-1:0] lane_in;
  lane_out_t [BITS_PER_BLOCK-1:0] lane_out;

  pbd_cfg_regs u_cfg_regs (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .filter_times (filter_times)
  );

  // Pipeline flow control
  assign advance     = !res_valid || results.ready;
  assign items.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.ready) begin
      in_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      blk_q <= items.block_index;
      raw_q <= items.raw_inputs;
    end
  end

  // Block select
  assign in_range = (32'(blk_q) < NUM_BLOCKS);
  assign rd_idx   = in_range ? BLK_W'(blk_q) : '0;
  assign update   = in_valid && advance && in_range;

  // Bit lanes
  for (genvar b = 0; b < BITS_PER_BLOCK; b++) begin : g_lane
    assign lane_in[b].cnt         = counters[rd_idx][b];
    assign lane_in[b].filter_time = filter_times[b];
    assign lane_in[b].raw         = raw_q[b];
    assign lane_in[b].prev_raw    = prev_raw[rd_idx][b];
    assign lane_in[b].filt        = filt_bits[rd_idx][b];

    pbd_lane u_lane (
      .lane_in  (lane_in[b]),
      .lane_out (lane_out[b])
    );

    assign cnt_next[b]  = lane_out[b].cnt;
    assign filt_next[b] = lane_out[b].filt;
  end

  // State write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        counters[i]  <= '0;
        prev_raw[i]  <= '0;
        filt_bits[i] <= '0;
      end
    end else if (update) begin
      counters[rd_idx]  <= cnt_next;
      prev_raw[rd_idx]  <= raw_q;
      filt_bits[rd_idx] <= filt_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      res_data <= in_range ? filt_next : '0;
    end
  end

  assign results.valid           = res_valid;
  assign results.filtered_inputs = res_data;

  // Checks
  a_res_follows: assert property (@(posedge clk) disable iff (rst)
    (advance && in_valid) |=> results.valid)
    else $error("result missing after input register advanced");

  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !items.ready |-> (in_valid && results.valid && !results.ready))
    else $error("input stalled without a full pipeline");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("held sample dropped");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    (advance && in_valid && !in_range) |=> (results.filtered_inputs == '0))
    else $error("out-of-range block gave nonzero result");

endmodule

/* hw/rtl/pbd_cfg_regs.sv */
module pbd_cfg_regs
  import pbd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  pbd_cfg_if.sink       cfg,
  output filter_times_t filter_times
);

  // Writes are always taken; indexes past the last register are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_times <= '0;
    end else if (cfg.valid && cfg.ready && (cfg.index <= REG_FILTER_TIME_LAST)) begin
      filter_times[3'(cfg.index - REG_FILTER_TIME_BIT0)] <= cnt_t'(cfg.data);
    end
  end

endmodule

/* hw/rtl/pbd_lane.sv */
module pbd_lane
  import pbd_pkg::*;
(
  input  lane_in_t  lane_in,
  output lane_out_t lane_out
);

  cnt_t cnt_dec;
  logic changed;

  // Counter saturates at zero
  assign cnt_dec = (lane_in.cnt != '0) ? cnt_t'(lane_in.cnt - 1'b1) : '0;
  assign changed = lane_in.raw ^ lane_in.prev_raw;

  always_comb begin
    lane_out.cnt  = cnt_dec;
    lane_out.filt = lane_in.filt;
    if (lane_in.filter_time == '0) begin
      // unfiltered bit passes straight through
      lane_out.filt = lane_in.raw;
    end else if (changed) begin
      lane_out.cnt = lane_in.filter_time;
    end else if (cnt_dec == '0) begin
      lane_out.filt = lane_in.raw;
    end
  end

endmodule
